// ===== hw/rtl/tmt_pkg.sv =====
// Package for the timed message table: command and result codes, and the
// controller/datapath command and status structures. No dependencies.
`timescale 1ns / 1ps
package tmt_pkg;

  localparam int CMD_W  = 3;
  localparam int KIND_W = 2;
  localparam int DEST_W = 8;
  localparam int MSG_W  = 16;
  localparam int PAY_W  = 32;
  localparam int DLY_W  = 32;

  localparam logic [CMD_W-1:0] CMD_ADD          = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL_FIRST = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL_ALL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT        = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK         = 3'd4;

  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_COUNT   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the incoming beat, clear scan state
    logic add_reply;   // store a new entry (if a slot is free) and reply
    logic scan_eval;   // evaluate the entry read at the scan index
    logic scan_reply;  // reply to cancel or count at the end of the scan
    logic step_idx;    // advance the scan index
    logic clr_idx;     // restart the scan index at slot zero
    logic use_best;    // address the earliest entry instead of the index
    logic emit;        // emit the entry just read as an expired message
  } tmt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic idx_last;
    logic total_zero;
    logic out_free;
    logic due_cur;
    logic emit_final;
  } tmt_sts_t;

endpackage

// ===== hw/rtl/timed_message_table.sv =====
// Top level of the timed message table: controller plus datapath.
// Depends on tmt_pkg, tmt_ctrl, tmt_dp (and through it tmt_ram).
`timescale 1ns / 1ps
// Usage:
// Command beats arrive on the cmd channel (cmd_valid/cmd_ready) carrying
// command, dest_id, message_id, payload_tag and delay. Result beats leave on
// the res channel (res_valid/res_ready); the final beat of a command carries
// last. Add, cancel and count produce one reply beat; a tick produces one
// expired-message beat per entry that fell due, the earliest deadline first
// and the rest in slot order, or no beat at all. Unknown codes are dropped.
// One command is worked on at a time. Cancel, count and tick scan every
// slot through the entry RAM's registered read port, a read state then an
// evaluate state per slot; on the emitting pass a tick rereads each due
// entry from the same read port and skips the slots that are not due.
// The result register decouples the channels: a new command is accepted
// while the previous reply still waits, and a stalled receiver only holds
// the block when it must hand over its next beat.
// Reset clears the valid bits, the time counter and the result valid flag;
// entry contents are not cleared and are only read behind a valid bit.
module timed_message_table import tmt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  logic [CMD_W-1:0]                     command,
  input  logic [DEST_W-1:0]                    dest_id,
  input  logic [MSG_W-1:0]                     message_id,
  input  logic [PAY_W-1:0]                     payload_tag,
  input  logic [DLY_W-1:0]                     delay,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [KIND_W-1:0]                    kind,
  output logic [DEST_W-1:0]                    out_dest_id,
  output logic [MSG_W-1:0]                     out_message_id,
  output logic [PAY_W-1:0]                     out_payload_tag,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     slot,
  output logic                                 accepted,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     match_count,
  output logic                                 last
);

  // Slot numbers and counts must reach TABLE_DEPTH itself.
  localparam int SLOT_W = $clog2(TABLE_DEPTH + 1);

  tmt_cmd_t cmd;
  tmt_sts_t sts;

  tmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (command),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH),
    .SLOT_W      (SLOT_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .command         (command),
    .dest_id         (dest_id),
    .message_id      (message_id),
    .payload_tag     (payload_tag),
    .delay           (delay),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .kind            (kind),
    .out_dest_id     (out_dest_id),
    .out_message_id  (out_message_id),
    .out_payload_tag (out_payload_tag),
    .slot            (slot),
    .accepted        (accepted),
    .match_count     (match_count),
    .last            (last)
  );

endmodule

// ===== hw/rtl/tmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tmt_ctrl.sv =====
// Controller state machine of the timed message table.
// Depends on tmt_pkg for the command and status structures.
`timescale 1ns / 1ps
module tmt_ctrl import tmt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic [CMD_W-1:0] command,
  output logic             cmd_ready,
  input  tmt_sts_t         sts,
  output tmt_cmd_t         cmd
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_ADD      = 9'b000000010,
    ST_SCAN_RD  = 9'b000000100,
    ST_SCAN_EV  = 9'b000001000,
    ST_SCAN_END = 9'b000010000,
    ST_FIRST_RD = 9'b000100000,
    ST_FIRST_EV = 9'b001000000,
    ST_EMIT_RD  = 9'b010000000,
    ST_EMIT_EV  = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd.load = 1'b1;
          case (command) inside
            CMD_ADD: state_next = ST_ADD;
            CMD_CANCEL_FIRST, CMD_CANCEL_ALL, CMD_COUNT, CMD_TICK:
              state_next = ST_SCAN_RD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (sts.out_free) begin
          cmd.add_reply = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_EV;
      ST_SCAN_EV: begin
        cmd.scan_eval = 1'b1;
        if (sts.idx_last) begin
          state_next = ST_SCAN_END;
        end else begin
          cmd.step_idx = 1'b1;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_END: begin
        if (sts.is_tick) begin
          state_next = sts.total_zero ? ST_IDLE : ST_FIRST_RD;
        end else if (sts.out_free) begin
          cmd.scan_reply = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FIRST_RD: begin
        cmd.use_best = 1'b1;
        state_next = ST_FIRST_EV;
      end
      ST_FIRST_EV: begin
        cmd.use_best = 1'b1;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.clr_idx = 1'b1;
          state_next = sts.emit_final ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        if (sts.due_cur) begin
          state_next = ST_EMIT_EV;
        end else begin
          cmd.step_idx = 1'b1;
        end
      end
      ST_EMIT_EV: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_final) begin
            state_next = ST_IDLE;
          end else begin
            cmd.step_idx = 1'b1;
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/tmt_dp.sv =====
// Datapath of the timed message table: entry RAM, valid and due bits, the
// time counter, scan registers and the result register.
// Depends on tmt_pkg and tmt_ram.
`timescale 1ns / 1ps
module tmt_dp import tmt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_WIDTH  = 32,
  parameter int SLOT_W      = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  tmt_cmd_t          cmd,
  output tmt_sts_t          sts,
  input  logic [CMD_W-1:0]  command,
  input  logic [DEST_W-1:0] dest_id,
  input  logic [MSG_W-1:0]  message_id,
  input  logic [PAY_W-1:0]  payload_tag,
  input  logic [DLY_W-1:0]  delay,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [KIND_W-1:0] kind,
  output logic [DEST_W-1:0] out_dest_id,
  output logic [MSG_W-1:0]  out_message_id,
  output logic [PAY_W-1:0]  out_payload_tag,
  output logic [SLOT_W-1:0] slot,
  output logic              accepted,
  output logic [SLOT_W-1:0] match_count,
  output logic              last
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int ENT_W = DEST_W + MSG_W + PAY_W + TIME_WIDTH;

  // Captured beat.
  logic [CMD_W-1:0]  cur_cmd;
  logic [DEST_W-1:0] cur_dest;
  logic [MSG_W-1:0]  cur_msg;
  logic [PAY_W-1:0]  cur_pay;
  logic [DLY_W-1:0]  cur_delay;

  logic [TIME_WIDTH-1:0]  now;
  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] due;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       best;
  logic [TIME_WIDTH-1:0]  best_dl;
  logic                   found;
  logic [SLOT_W-1:0]      total;
  logic [SLOT_W-1:0]      sent;

  // Lowest free slot.
  logic             free_any;
  logic [IDX_W-1:0] free_idx;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  logic [IDX_W-1:0]      raddr;
  logic [ENT_W-1:0]      rdata;
  logic [ENT_W-1:0]      wdata;
  logic [DEST_W-1:0]     rd_dest;
  logic [MSG_W-1:0]      rd_msg;
  logic [PAY_W-1:0]      rd_pay;
  logic [TIME_WIDTH-1:0] rd_dl;
  logic                  ram_we;

  assign raddr  = cmd.use_best ? best : idx;
  assign ram_we = cmd.add_reply && free_any;
  assign wdata  = {cur_dest, cur_msg, cur_pay, now + TIME_WIDTH'(cur_delay)};
  assign {rd_dest, rd_msg, rd_pay, rd_dl} = rdata;

  tmt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic is_tick;
  logic hit;
  logic better;

  assign is_tick = (cur_cmd == CMD_TICK);
  assign hit = is_tick ? (valid[idx] && rd_dl <= now)
                       : (valid[idx] && rd_dest == cur_dest && rd_msg == cur_msg);
  assign better = !found || rd_dl < best_dl;

  logic res_load;
  assign res_load = cmd.add_reply || cmd.scan_reply || cmd.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      now       <= '0;
      valid     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.load && command == CMD_TICK) begin
        now <= now + 1'b1;
      end
      if (ram_we) begin
        valid[free_idx] <= 1'b1;
      end
      if (cmd.scan_eval && hit && cur_cmd == CMD_CANCEL_ALL) begin
        valid[idx] <= 1'b0;
      end
      if (cmd.scan_reply && found && cur_cmd == CMD_CANCEL_FIRST) begin
        valid[best] <= 1'b0;
      end
      if (cmd.emit) begin
        valid[raddr] <= 1'b0;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Scan/beat registers; no reset needed, load sets all but best/best_dl.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_cmd   <= command;
      cur_dest  <= dest_id;
      cur_msg   <= message_id;
      cur_pay   <= payload_tag;
      cur_delay <= delay;
      idx       <= '0;
      found     <= 1'b0;
      total     <= '0;
      sent      <= '0;
      due       <= '0;
    end else begin
      if (cmd.scan_eval && hit) begin
        total <= total + 1'b1;
        due[idx] <= is_tick;
        if (better) begin
          found   <= 1'b1;
          best    <= idx;
          best_dl <= rd_dl;
        end
      end
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.step_idx) begin
        idx <= idx + 1'b1;
      end
      if (cmd.emit) begin
        due[raddr] <= 1'b0;
        sent <= sent + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (res_load) begin
      if (cmd.add_reply) begin
        kind            <= KIND_ADD;
        out_dest_id     <= '0;
        out_message_id  <= '0;
        out_payload_tag <= '0;
        slot            <= free_any ? SLOT_W'(free_idx) : SLOT_W'(TABLE_DEPTH);
        accepted        <= free_any;
        match_count     <= '0;
        last            <= 1'b1;
      end else if (cmd.scan_reply) begin
        out_dest_id     <= '0;
        out_message_id  <= '0;
        out_payload_tag <= '0;
        slot            <= '0;
        last            <= 1'b1;
        if (cur_cmd == CMD_COUNT) begin
          kind        <= KIND_COUNT;
          accepted    <= 1'b0;
          match_count <= total;
        end else if (cur_cmd == CMD_CANCEL_FIRST) begin
          kind        <= KIND_CANCEL;
          accepted    <= found;
          match_count <= SLOT_W'(found);
        end else begin
          kind        <= KIND_CANCEL;
          accepted    <= (total != '0);
          match_count <= total;
        end
      end else begin
        kind            <= KIND_EXPIRED;
        out_dest_id     <= rd_dest;
        out_message_id  <= rd_msg;
        out_payload_tag <= rd_pay;
        slot            <= '0;
        accepted        <= 1'b0;
        match_count     <= '0;
        last            <= sts.emit_final;
      end
    end
  end

  assign sts.is_tick    = is_tick;
  assign sts.idx_last   = (idx == IDX_W'(TABLE_DEPTH - 1));
  assign sts.total_zero = (total == '0);
  assign sts.out_free   = !res_valid || res_ready;
  assign sts.due_cur    = due[idx];
  assign sts.emit_final = ((sent + 1'b1) == total);

endmodule

// ===== hw/rtl/tmt_checker.sv =====
// Port-level assertions for the timed message table, bound to the top level.
// Depends on tmt_pkg and timed_message_table.
`timescale 1ns / 1ps
module tmt_checker import tmt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int SLOT_W      = 5
) (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [KIND_W-1:0] kind,
  input logic [SLOT_W-1:0] slot,
  input logic              accepted,
  input logic              last
);

  // No beat is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat offered right after reset");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(last))
    else $error("stalled result beat changed");

  // Replies are always the only and final beat of their command.
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_EXPIRED |-> last)
    else $error("reply beat without last");

  // An add reply reports full exactly when it was refused.
  a_add_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_ADD |-> accepted == (slot != SLOT_W'(TABLE_DEPTH)))
    else $error("add reply slot and accepted disagree");

  // Count and expiry beats never claim acceptance.
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_COUNT || kind == KIND_EXPIRED) |-> !accepted)
    else $error("accepted set on count or expiry beat");

endmodule

bind timed_message_table tmt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .SLOT_W      ($clog2(TABLE_DEPTH + 1))
) u_tmt_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .kind      (kind),
  .slot      (slot),
  .accepted  (accepted),
  .last      (last)
);

// ===== bench/tb_timed_message_table.sv =====
// Self-checking testbench for timed_message_table: drives command beats,
// predicts every result beat with its own table model and checks them in order.
// Depends on tmt_pkg and the timed_message_table RTL.
`timescale 1ns / 1ps
module tb_timed_message_table;
  import tmt_pkg::*;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CMD_W-1:0] CMD_LAST_CODE = 3'd7;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  logic [CMD_W-1:0] command = CMD_ADD;
  logic [DEST_W-1:0] dest_id = '0;
  logic [MSG_W-1:0] message_id = '0;
  logic [PAY_W-1:0] payload_tag = '0;
  logic [DLY_W-1:0] delay = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [DEST_W-1:0] out_dest_id;
  logic [MSG_W-1:0] out_message_id;
  logic [PAY_W-1:0] out_payload_tag;
  logic [CNT_W-1:0] slot;
  logic accepted;
  logic [CNT_W-1:0] match_count;
  logic last;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEST_W-1:0] dest;
    logic [MSG_W-1:0] msg;
    logic [PAY_W-1:0] pay;
    logic [CNT_W-1:0] slot;
    logic acc;
    logic [CNT_W-1:0] cnt;
    logic last;
  } beat_t;

  // Pending result beats, oldest first.
  beat_t pending_beats[$];

  // Shadow copy of the message table.
  logic entry_live[DEPTH];
  logic [DEST_W-1:0] entry_dest[DEPTH];
  logic [MSG_W-1:0] entry_msg[DEPTH];
  logic [PAY_W-1:0] entry_pay[DEPTH];
  logic [31:0] entry_due[DEPTH];
  logic [31:0] now_ticks;

  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  timed_message_table #(.TABLE_DEPTH(DEPTH), .TIME_WIDTH(32)) DUT (.*);

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed_message_table: mismatch");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic beat_t reply(input logic [KIND_W-1:0] k, input int s,
                                  input logic a, input int c);
    beat_t b;
    b = '0;
    b.kind = k;
    b.slot = s[CNT_W-1:0];
    b.acc = a;
    b.cnt = c[CNT_W-1:0];
    b.last = 1'b1;
    return b;
  endfunction

  function automatic beat_t expired(input int i, input logic fin);
    beat_t b;
    b = '0;
    b.kind = KIND_EXPIRED;
    b.dest = entry_dest[i];
    b.msg = entry_msg[i];
    b.pay = entry_pay[i];
    b.last = fin;
    return b;
  endfunction

  // Applies one accepted command to the shadow table and queues its beats.
  task automatic predict_table(input logic [CMD_W-1:0] c, input logic [DEST_W-1:0] d,
                               input logic [MSG_W-1:0] m, input logic [PAY_W-1:0] p,
                               input logic [DLY_W-1:0] dl);
    int best;
    int total;
    int n;
    logic due[DEPTH];
    best = -1;
    total = 0;
    n = 0;
    case (c)
      CMD_ADD: begin
        for (int i = 0; i < DEPTH; i++)
          if (!entry_live[i] && best < 0) best = i;
        if (best >= 0) begin
          entry_live[best] = 1'b1;
          entry_dest[best] = d;
          entry_msg[best] = m;
          entry_pay[best] = p;
          entry_due[best] = now_ticks + dl;
          pending_beats.push_back(reply(KIND_ADD, best, 1'b1, 0));
        end else begin
          pending_beats.push_back(reply(KIND_ADD, DEPTH, 1'b0, 0));
        end
      end
      CMD_CANCEL_FIRST: begin
        for (int i = 0; i < DEPTH; i++)
          if (entry_live[i] && entry_dest[i] == d && entry_msg[i] == m &&
              (best < 0 || entry_due[i] < entry_due[best])) best = i;
        if (best >= 0) entry_live[best] = 1'b0;
        pending_beats.push_back(reply(KIND_CANCEL, 0, best >= 0, best >= 0 ? 1 : 0));
      end
      CMD_CANCEL_ALL, CMD_COUNT: begin
        for (int i = 0; i < DEPTH; i++)
          if (entry_live[i] && entry_dest[i] == d && entry_msg[i] == m) begin
            total++;
            if (c == CMD_CANCEL_ALL) entry_live[i] = 1'b0;
          end
        if (c == CMD_CANCEL_ALL)
          pending_beats.push_back(reply(KIND_CANCEL, 0, total != 0, total));
        else
          pending_beats.push_back(reply(KIND_COUNT, 0, 1'b0, total));
      end
      CMD_TICK: begin
        now_ticks = now_ticks + 1;
        for (int i = 0; i < DEPTH; i++) begin
          due[i] = entry_live[i] && entry_due[i] <= now_ticks;
          if (due[i]) begin
            total++;
            if (best < 0 || entry_due[i] < entry_due[best]) best = i;
          end
        end
        if (best >= 0) begin
          // Earliest deadline leaves first, the others follow in slot order.
          pending_beats.push_back(expired(best, total == 1));
          entry_live[best] = 1'b0;
          due[best] = 1'b0;
          n = 1;
          for (int i = 0; i < DEPTH; i++)
            if (due[i]) begin
              pending_beats.push_back(expired(i, n + 1 == total));
              entry_live[i] = 1'b0;
              n++;
            end
        end
      end
      default: ;
    endcase
  endtask

  // Sends one command beat; valid stays high from one beat to the next unless
  // the sender decides to idle first.
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [DEST_W-1:0] d,
                          input logic [MSG_W-1:0] m, input logic [PAY_W-1:0] p,
                          input logic [DLY_W-1:0] dl);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command <= c;
    dest_id <= d;
    message_id <= m;
    payload_tag <= p;
    delay <= dl;
    do @(posedge clk); while (!(cmd_valid && cmd_ready));
    predict_table(c, d, m, p, dl);
  endtask

  // Result checker, also the receiver's random stall.
  always @(posedge clk) begin
    beat_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_beats.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = pending_beats.pop_front();
        if (kind !== want.kind) report($sformatf("kind %0d, want %0d", kind, want.kind));
        if (out_dest_id !== want.dest)
          report($sformatf("dest %0h, want %0h", out_dest_id, want.dest));
        if (out_message_id !== want.msg)
          report($sformatf("message %0h, want %0h", out_message_id, want.msg));
        if (out_payload_tag !== want.pay)
          report($sformatf("payload %0h, want %0h", out_payload_tag, want.pay));
        if (slot !== want.slot) report($sformatf("slot %0d, want %0d", slot, want.slot));
        if (accepted !== want.acc)
          report($sformatf("accepted %0b, want %0b", accepted, want.acc));
        if (match_count !== want.cnt)
          report($sformatf("count %0d, want %0d", match_count, want.cnt));
        if (last !== want.last) report($sformatf("last %0b, want %0b", last, want.last));
      end
    end
    res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Extremes, every command, deadline ties, wrapped deadlines, a full table.
  task automatic test_directed();
    send_cmd(CMD_ADD, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    send_cmd(CMD_ADD, 8'h00, 16'h0000, 32'h0000_0000, 32'd1);
    send_cmd(CMD_ADD, 8'hA5, 16'h5A5A, 32'h1234_5678, 32'd1);
    send_cmd(CMD_TICK, 8'h00, 16'h0000, 32'h0, 32'h0);
    send_cmd(CMD_TICK, 8'h00, 16'h0000, 32'h0, 32'h0);
    // At time 2 a maximal delay wraps to a deadline already passed.
    send_cmd(CMD_ADD, 8'h11, 16'h2222, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    send_cmd(CMD_ADD, 8'h11, 16'h2222, 32'hCAFE_F00D, 32'd3);
    send_cmd(CMD_ADD, 8'h11, 16'h2222, 32'h0BAD_F00D, 32'd2);
    send_cmd(CMD_COUNT, 8'h11, 16'h2222, 32'h0, 32'h0);
    send_cmd(CMD_CANCEL_FIRST, 8'h11, 16'h2222, 32'h0, 32'h0);
    send_cmd(CMD_CANCEL_FIRST, 8'h33, 16'h4444, 32'h0, 32'h0);
    send_cmd(CMD_CANCEL_ALL, 8'h11, 16'h2222, 32'h0, 32'h0);
    send_cmd(CMD_CANCEL_ALL, 8'h11, 16'h2222, 32'h0, 32'h0);
    for (int c = CMD_TICK + 1; c <= CMD_LAST_CODE; c++)
      send_cmd(c[CMD_W-1:0], 8'h77, 16'h7777, 32'h7777_7777, 32'd0);
    // Fill the table past its end, then let everything fall due in one tick.
    for (int i = 0; i <= DEPTH; i++)
      send_cmd(CMD_ADD, i[7:0], 16'h0100, $urandom, (i % 3 == 0) ? 32'd0 : 32'd1);
    send_cmd(CMD_TICK, 8'h00, 16'h0000, 32'h0, 32'h0);
  endtask

  // Mostly well-formed traffic on a few keys so that cancels and counts hit,
  // with full-range fields and unused codes mixed in.
  task automatic test_random(input int s_idle, input int r_idle, input int n_items);
    int roll;
    logic [CMD_W-1:0] c;
    logic [DEST_W-1:0] d;
    logic [MSG_W-1:0] m;
    logic [DLY_W-1:0] dl;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (roll < 35) c = CMD_ADD;
      else if (roll < 68) c = CMD_TICK;
      else if (roll < 78) c = CMD_CANCEL_FIRST;
      else if (roll < 86) c = CMD_CANCEL_ALL;
      else if (roll < 95) c = CMD_COUNT;
      else c = CMD_W'($urandom_range(CMD_TICK + 1, CMD_LAST_CODE));
      if ($urandom_range(9) == 0) begin
        d = DEST_W'($urandom);
        m = MSG_W'($urandom);
      end else begin
        d = DEST_W'($urandom_range(0, 2));
        m = MSG_W'($urandom_range(0, 2));
      end
      dl = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 6);
      send_cmd(c, d, m, $urandom, dl);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) entry_live[i] = 1'b0;
    now_ticks = '0;
    send_idle_pct = 22;
    recv_idle_pct = 69;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(22, 69, 28);
    test_random(69, 22, 28);
    test_random(0, 0, 20);
    cmd_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    // A tick with nothing due may still be scanning; give it time to finish.
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("timed_message_table: match");
    end else begin
      $display("timed_message_table: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tmt_pkg.sv
hw/rtl/tmt_ram.sv
hw/rtl/tmt_ctrl.sv
hw/rtl/tmt_dp.sv
hw/rtl/timed_message_table.sv
hw/rtl/tmt_checker.sv
bench/tb_timed_message_table.sv
